>>> hw/rtl/bdr_pkg.sv
// bdr_pkg: shared types, field widths, register map and reset values
// for the binary dilation row core. No dependencies.
package bdr_pkg;

   localparam int PIX_W  = 64;
   localparam int IDX_W  = 12;
   localparam int MASK_W = 25;
   localparam int ORG_W  = 3;
   localparam int WID_W  = 7;
   localparam int HGT_W  = 13;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_MASK       = 3'd0,
      REG_ORIGIN_ROW = 3'd1,
      REG_ORIGIN_COL = 3'd2,
      REG_WIDTH      = 3'd3,
      REG_HEIGHT     = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask_bits;
      logic [ORG_W-1:0]  origin_row;
      logic [ORG_W-1:0]  origin_col;
      logic [WID_W-1:0]  image_width;
      logic [HGT_W-1:0]  image_height;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      mask_bits:    25'h1FF_FFFF,
      origin_row:   3'd2,
      origin_col:   3'd2,
      image_width:  7'd64,
      image_height: 13'd480
   };

   typedef struct packed {
      logic [PIX_W-1:0] dilated_pixels;
      logic [IDX_W-1:0] row_index;
      logic             frame_end;
   } rsp_item_type;

   function automatic logic [PIX_W-1:0] width_mask(input logic [WID_W-1:0] w);
      logic [PIX_W-1:0] m;
      for (int c = 0; c < PIX_W; c++) begin
         m[c] = (int'(w) > c);
      end
      return m;
   endfunction

endpackage

>>> hw/rtl/binary_dilation_rows_core.sv
// binary_dilation_rows_core: streaming binary dilation, one packed row per transfer.
// Each accepted req row is registered in bdr_ctrl, each result row in bdr_out_buf.
// Throughput: one req transfer per cycle unless req_stall; a req row that releases
// rows holds req_stall until the last is emitted, one per cycle if a slot is free.
// Reset (synchronous): counters, buffer and handshake cleared, registers to defaults.
// Depends on bdr_pkg, bdr_csr, bdr_ctrl, bdr_kernel, bdr_out_buf.
module binary_dilation_rows_core
   import bdr_pkg::*;
#(
   parameter int MASK_SIZE  = 5,
   parameter int ROW_WIDTH  = 64,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIX_W-1:0]  req_row_pixels,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIX_W-1:0]  rsp_dilated_pixels,
   output logic [IDX_W-1:0]  rsp_row_index,
   output logic              rsp_frame_end
);

   cfg_type      cfg;
   logic         slot_free;
   logic         push;
   rsp_item_type push_item;
   rsp_item_type rsp_item;

   bdr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bdr_ctrl #(
      .MASK_SIZE  (MASK_SIZE),
      .ROW_WIDTH  (ROW_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_pixels (req_row_pixels),
      .slot_free      (slot_free),
      .push           (push),
      .push_item      (push_item)
   );

   bdr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_dilated_pixels = rsp_item.dilated_pixels;
   assign rsp_row_index      = rsp_item.row_index;
   assign rsp_frame_end      = rsp_item.frame_end;

endmodule

>>> hw/rtl/bdr_csr.sv
// bdr_csr: APB-style register file holding the structuring element,
// origin and image geometry. Depends on bdr_pkg.
module bdr_csr
   import bdr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MASK:       cfg_in.mask_bits    = pwdata[MASK_W-1:0];
            REG_ORIGIN_ROW: cfg_in.origin_row   = pwdata[ORG_W-1:0];
            REG_ORIGIN_COL: cfg_in.origin_col   = pwdata[ORG_W-1:0];
            REG_WIDTH:      cfg_in.image_width  = pwdata[WID_W-1:0];
            REG_HEIGHT:     cfg_in.image_height = pwdata[HGT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MASK:       prdata = DATA_W'(cfg_ff.mask_bits);
         REG_ORIGIN_ROW: prdata = DATA_W'(cfg_ff.origin_row);
         REG_ORIGIN_COL: prdata = DATA_W'(cfg_ff.origin_col);
         REG_WIDTH:      prdata = DATA_W'(cfg_ff.image_width);
         REG_HEIGHT:     prdata = DATA_W'(cfg_ff.image_height);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/bdr_kernel.sv
// bdr_kernel: window OR for one output row over the held input rows.
// Per column offset, gathers the rows whose element row is active, then shifts.
// Depends on bdr_pkg.
module bdr_kernel
   import bdr_pkg::*;
#(
   parameter int MASK_SIZE = 5,
   parameter int ROW_WIDTH = 64,
   parameter int SW        = 16
) (
   input  logic [ROW_WIDTH-1:0] rows [MASK_SIZE],
   input  logic [MASK_SIZE-1:0] slot_ok,
   input  logic signed [SW-1:0] base,
   input  logic [ROW_WIDTH-1:0] wmask,
   input  cfg_type              cfg,
   output logic [ROW_WIDTH-1:0] dil_row
);

   localparam int CELLS = MASK_SIZE * MASK_SIZE;

   logic [CELLS-1:0] mask_ext;

   assign mask_ext = CELLS'(cfg.mask_bits);

   // slot k holds the input row that element row (base - k) looks at
   always_comb begin
      logic [ROW_WIDTH-1:0] src;
      logic [ROW_WIDTH-1:0] acc;
      logic                 hit;
      acc = '0;
      for (int j = 0; j < MASK_SIZE; j++) begin
         src = '0;
         for (int k = 0; k < MASK_SIZE; k++) begin
            hit = 1'b0;
            for (int i = 0; i < MASK_SIZE; i++) begin
               if (mask_ext[i*MASK_SIZE+j] && ((base - SW'(k)) == SW'(i))) begin
                  hit = 1'b1;
               end
            end
            if (hit && slot_ok[k]) begin
               src = src | (rows[k] & wmask);
            end
         end
         if (j >= int'(cfg.origin_col)) begin
            acc = acc | (src >> (j - int'(cfg.origin_col)));
         end else begin
            acc = acc | (src << (int'(cfg.origin_col) - j));
         end
      end
      dil_row = acc & wmask;
   end

endmodule

>>> hw/rtl/bdr_ctrl.sv
// bdr_ctrl: row store, frame counters and emit sequencing; one output row per cycle while a buffer slot is free.
// Depends on bdr_pkg and bdr_kernel.
module bdr_ctrl
   import bdr_pkg::*;
#(
   parameter int MASK_SIZE  = 5,
   parameter int ROW_WIDTH  = 64,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_row_pixels,
   input  logic             slot_free,
   output logic             push,
   output rsp_item_type     push_item
);

   localparam int CW = $clog2(MAX_HEIGHT + 1);
   localparam int SW = CW + 3;
   localparam int NW = $clog2(MASK_SIZE + 1);
   localparam int HW = (CW > HGT_W) ? CW : HGT_W;

   logic [ROW_WIDTH-1:0] store_ff [MASK_SIZE];
   logic [ROW_WIDTH-1:0] store_in [MASK_SIZE];
   logic [CW-1:0]        rcv_ff, rcv_in, emt_ff, emt_in;
   logic [NW-1:0]        n_ff, n_in;
   logic                 busy_ff, busy_in;

   logic [HW-1:0]        h_ext;
   logic [CW-1:0]        h_eff;
   logic [ORG_W-1:0]     orow_eff, look;
   logic [PIX_W-1:0]     wmask_full;
   logic [ROW_WIDTH-1:0] wmask;
   logic [CW:0]          emt_p1, emt_look, emt_look1;
   logic                 last, ok_now, ok_next, emit, done, accept, clear;
   logic [MASK_SIZE-1:0] slot_ok;
   logic signed [SW-1:0] base;
   logic [ROW_WIDTH-1:0] dil_row;

   assign h_ext = HW'(cfg.image_height);
   assign h_eff = (h_ext == '0) ? CW'(1) :
                  (h_ext > HW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(h_ext);
   assign orow_eff = (cfg.origin_row > ORG_W'(MASK_SIZE - 1)) ?
                     ORG_W'(MASK_SIZE - 1) : cfg.origin_row;
   assign look       = ORG_W'(MASK_SIZE - 1) - orow_eff;
   assign wmask_full = width_mask(cfg.image_width);
   assign wmask      = wmask_full[ROW_WIDTH-1:0];

   assign last      = (rcv_ff >= h_eff);
   assign emt_p1    = {1'b0, emt_ff} + (CW+1)'(1);
   assign emt_look  = {1'b0, emt_ff} + (CW+1)'(look);
   assign emt_look1 = emt_p1 + (CW+1)'(look);

   assign ok_now  = busy_ff && (emt_ff < h_eff) && (n_ff < NW'(MASK_SIZE)) &&
                    (last || (emt_look < {1'b0, rcv_ff}));
   assign ok_next = (emt_p1 < {1'b0, h_eff}) && ((n_ff + NW'(1)) < NW'(MASK_SIZE)) &&
                    (last || (emt_look1 < {1'b0, rcv_ff}));
   assign emit    = ok_now && slot_free;
   assign done    = busy_ff && (!ok_now || (emit && !ok_next));
   assign clear   = done && last;

   assign req_stall = busy_ff && !done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int k = 0; k < MASK_SIZE; k++) begin
         slot_ok[k] = ((CW+1)'(k) < {1'b0, rcv_ff}) &&
                      (({1'b0, rcv_ff} - (CW+1)'(k) - (CW+1)'(1)) < {1'b0, h_eff});
      end
   end

   assign base = $signed(SW'(rcv_ff)) - $signed(SW'(emt_ff)) - SW'(1) +
                 $signed(SW'(orow_eff));

   bdr_kernel #(
      .MASK_SIZE (MASK_SIZE),
      .ROW_WIDTH (ROW_WIDTH),
      .SW        (SW)
   ) u_kernel (
      .rows    (store_ff),
      .slot_ok (slot_ok),
      .base    (base),
      .wmask   (wmask),
      .cfg     (cfg),
      .dil_row (dil_row)
   );

   assign push                     = emit;
   assign push_item.dilated_pixels = PIX_W'(dil_row);
   assign push_item.row_index      = IDX_W'(emt_ff);
   assign push_item.frame_end      = (emt_ff == (h_eff - CW'(1)));

   always_comb begin
      store_in = store_ff;
      if (accept) begin
         store_in[0] = req_row_pixels[ROW_WIDTH-1:0] & wmask;
         for (int k = 1; k < MASK_SIZE; k++) begin
            store_in[k] = store_ff[k-1];
         end
      end
      rcv_in = clear ? '0 : rcv_ff;
      if (accept) begin
         rcv_in = rcv_in + CW'(1);
      end
      emt_in  = clear ? '0 : (emit ? emt_p1[CW-1:0] : emt_ff);
      n_in    = accept ? '0 : (emit ? (n_ff + NW'(1)) : n_ff);
      busy_in = accept || (busy_ff && !done);
   end

   // row store needs no reset: slots beyond the received count are never read
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_ff  <= '0;
         emt_ff  <= '0;
         n_ff    <= '0;
         busy_ff <= 1'b0;
      end else begin
         rcv_ff  <= rcv_in;
         emt_ff  <= emt_in;
         n_ff    <= n_in;
         busy_ff <= busy_in;
      end
   end

endmodule

>>> hw/rtl/bdr_out_buf.sv
// bdr_out_buf: two-entry result buffer between the emit logic and the rsp channel.
// Depends on bdr_pkg.
module bdr_out_buf
   import bdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         slot_free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   rsp_item_type buf_ff [2];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         pop;

   assign slot_free = (cnt_ff != 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_item  = buf_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/bdr_checker.sv
// bdr_checker: port-level checks for binary_dilation_rows_core, bound to the top level.
// Depends on bdr_pkg.
module bdr_checker
   import bdr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              pready,
   input logic              req_valid,
   input logic              req_stall,
   input logic [PIX_W-1:0]  req_row_pixels,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [PIX_W-1:0]  rsp_dilated_pixels,
   input logic [IDX_W-1:0]  rsp_row_index,
   input logic              rsp_frame_end
);

   // after reset nothing is pending and input is open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pending state after reset");

   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_row_pixels)))
      else $error("stalled req transfer changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_dilated_pixels) && $stable(rsp_row_index) &&
          $stable(rsp_frame_end)))
      else $error("stalled rsp transfer changed");

   // the row after a frame end transfer starts the next frame
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_frame_end) |=>
         (!rsp_valid || (rsp_row_index == '0)))
      else $error("row after frame end is not row zero");

endmodule

bind binary_dilation_rows_core bdr_checker u_bdr_checker (.*);
